// ----- rtl/crc16r_pkg.sv -----
// crc16r_pkg: shared types, constants and the byte fold function
// for the selectable reflected crc-16 unit; no dependencies
`timescale 1ns / 1ps

package crc16r_pkg;

  localparam int unsigned CrcW    = 16;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned SelW    = 2;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned NumPoly = 4;

  localparam logic [CrcW-1:0] PolyResetZero  = 16'h8480;
  localparam logic [CrcW-1:0] PolyResetOne   = 16'hA001;
  localparam logic [CrcW-1:0] PolyResetTwo   = 16'h8621;
  localparam logic [CrcW-1:0] PolyResetThree = 16'hE950;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_POLY_SELECT = 3'd0,
    CFG_INIT_VALUE  = 3'd1,
    CFG_POLY_ZERO   = 3'd2,
    CFG_POLY_ONE    = 3'd3,
    CFG_POLY_TWO    = 3'd4,
    CFG_POLY_THREE  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [CrcW-1:0] init_value;
    logic [CrcW-1:0] poly;
  } crc_cfg_t;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             first_byte;
    logic             last_byte;
  } in_beat_t;

  // xor the byte into the low bits, then eight lsb-first shift steps
  function automatic logic [CrcW-1:0] fold_byte(
    input logic [CrcW-1:0]  reg_in,
    input logic [ByteW-1:0] data,
    input logic [CrcW-1:0]  poly
  );
    logic [CrcW-1:0] r;
    logic            out_bit;
    r = reg_in ^ {{(CrcW-ByteW){1'b0}}, data};
    for (int k = 0; k < ByteW; k++) begin
      out_bit = r[0];
      r = {1'b0, r[CrcW-1:1]};
      if (out_bit) begin
        r = r ^ poly;
      end
    end
    return r;
  endfunction

endpackage

// ----- rtl/crc16r_cfg_regs.sv -----
// crc16r_cfg_regs: configuration register file, polynomial table and select
// depends on crc16r_pkg
`timescale 1ns / 1ps

module crc16r_cfg_regs
  import crc16r_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output crc_cfg_t            cfg_o
);

  logic [SelW-1:0] poly_sel_q;
  logic [CrcW-1:0] init_q;
  logic [CrcW-1:0] poly_q [NumPoly];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_sel_q <= '0;
      init_q     <= '0;
      poly_q[0]  <= PolyResetZero;
      poly_q[1]  <= PolyResetOne;
      poly_q[2]  <= PolyResetTwo;
      poly_q[3]  <= PolyResetThree;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_POLY_SELECT: poly_sel_q <= cfg_data_i[SelW-1:0];
        CFG_INIT_VALUE:  init_q     <= cfg_data_i[CrcW-1:0];
        CFG_POLY_ZERO:   poly_q[0]  <= cfg_data_i[CrcW-1:0];
        CFG_POLY_ONE:    poly_q[1]  <= cfg_data_i[CrcW-1:0];
        CFG_POLY_TWO:    poly_q[2]  <= cfg_data_i[CrcW-1:0];
        CFG_POLY_THREE:  poly_q[3]  <= cfg_data_i[CrcW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o.init_value = init_q;
  assign cfg_o.poly       = poly_q[poly_sel_q];

endmodule

// ----- rtl/crc16r_in_stage.sv -----
// crc16r_in_stage: input register for one beat, stalls on downstream ready
// depends on crc16r_pkg
`timescale 1ns / 1ps

module crc16r_in_stage
  import crc16r_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     up_valid_i,
  output logic     up_ready_o,
  input  in_beat_t up_beat_i,
  output logic     dn_valid_o,
  input  logic     dn_ready_i,
  output in_beat_t dn_beat_o
);

  logic     valid_q, valid_d;
  in_beat_t beat_q;

  assign up_ready_o = !valid_q || dn_ready_i;
  assign valid_d    = up_valid_i || (valid_q && !dn_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_valid_i && up_ready_o) begin
      beat_q <= up_beat_i;
    end
  end

  assign dn_valid_o = valid_q;
  assign dn_beat_o  = beat_q;

endmodule

// ----- rtl/crc16r_fold_stage.sv -----
// crc16r_fold_stage: running crc register, byte fold and output register
// depends on crc16r_pkg
`timescale 1ns / 1ps

module crc16r_fold_stage
  import crc16r_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  crc_cfg_t        cfg_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  in_beat_t        in_beat_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [CrcW-1:0] out_crc_o,
  output logic            out_last_o
);

  logic            crc_en;
  logic [CrcW-1:0] crc_q, crc_d;
  logic            out_valid_q, out_valid_d;
  logic [CrcW-1:0] out_crc_q;
  logic            out_last_q;
  logic [CrcW-1:0] seed;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign crc_en      = in_valid_i && in_ready_o;
  assign seed        = in_beat_i.first_byte ? cfg_i.init_value : crc_q;
  assign crc_d       = fold_byte(seed, in_beat_i.data_byte, cfg_i.poly);
  assign out_valid_d = crc_en || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (crc_en) begin
        crc_q <= crc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (crc_en) begin
      out_crc_q  <= crc_d;
      out_last_q <= in_beat_i.last_byte;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_crc_o   = out_crc_q;
  assign out_last_o  = out_last_q;

  a_fold_loads_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    crc_en |=> out_valid_q)
    else $error("folded beat not presented");

  a_out_matches_crc : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_crc_q == crc_q))
    else $error("output crc differs from running register");

  a_crc_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !crc_en |=> $stable(crc_q))
    else $error("running crc changed without a beat");

endmodule

// ----- rtl/selectable_crc16_reflected_unit.sv -----
// selectable_crc16_reflected_unit: top level of the byte-serial reflected crc-16
// depends on crc16r_pkg, crc16r_cfg_regs, crc16r_in_stage, crc16r_fold_stage
// a beat passes the input register, then the fold stage output register, to the master side
// throughput: one byte per clock unless the output stalls; the 8-step fold is combinational
// off the input register, and a finished result waits in the output register while the next byte is taken
// reset: running crc, select and init clear to zero, polynomial table to its defaults
`timescale 1ns / 1ps

module selectable_crc16_reflected_unit
  import crc16r_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [7:0] data_byte
  input  logic                s_axis_tuser,   // [0] first_byte
  input  logic                s_axis_tlast,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [15:0]         m_axis_tdata,   // [15:0] crc_value
  output logic                m_axis_tlast,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  crc_cfg_t cfg;
  in_beat_t up_beat, dn_beat;
  logic     dn_valid, dn_ready;

  assign up_beat.data_byte  = s_axis_tdata;
  assign up_beat.first_byte = s_axis_tuser;
  assign up_beat.last_byte  = s_axis_tlast;

  crc16r_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  crc16r_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .up_valid_i (s_axis_tvalid),
    .up_ready_o (s_axis_tready),
    .up_beat_i  (up_beat),
    .dn_valid_o (dn_valid),
    .dn_ready_i (dn_ready),
    .dn_beat_o  (dn_beat)
  );

  crc16r_fold_stage u_fold_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (dn_valid),
    .in_ready_o  (dn_ready),
    .in_beat_i   (dn_beat),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_crc_o   (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

// ----- tb/tb.sv -----
// tb: self-checking testbench for selectable_crc16_reflected_unit
// streams message bytes, predicts the running crc per beat and compares each result
// depends on crc16r_pkg and the rtl of the unit
`timescale 1ns / 1ps

module tb;
  import crc16r_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 200;
  localparam int unsigned MaxReports = 10;
  localparam logic [CfgIdxW-1:0] CfgIdxSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgIdxSpareHi = 3'd7;

  typedef struct packed {
    logic [CrcW-1:0] crc;
    logic            done;
  } crc_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [ByteW-1:0]    s_axis_tdata = '0;   // [7:0] data_byte
  logic                s_axis_tuser = 1'b0; // [0] first_byte
  logic                s_axis_tlast = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [CrcW-1:0]     m_axis_tdata;        // [15:0] crc_value
  logic                m_axis_tlast;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  // predictor state
  logic [CrcW-1:0] crc_state;
  logic [SelW-1:0] poly_sel;
  logic [CrcW-1:0] init_word;
  logic [CrcW-1:0] poly_tab [NumPoly];
  crc_result_t     crc_expected_q [$];

  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  int unsigned hold_asked = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  int unsigned beats_sent = 0;
  int unsigned results_checked = 0;
  int unsigned messages_sent = 0;
  int unsigned reg_writes = 0;

  selectable_crc16_reflected_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               crc_expected_q.size());
      $display("[selectable_crc16_reflected_unit] ERROR");
      $finish;
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_asked) begin
      hold_left   <= HoldCycles;
      hold_served <= hold_served + 1;
    end
  end

  function automatic logic [CrcW-1:0] crc_fold(input logic [CrcW-1:0] start,
                                               input logic [ByteW-1:0] data,
                                               input logic [CrcW-1:0] poly);
    logic [CrcW-1:0] acc;
    acc = start ^ {{(CrcW-ByteW){1'b0}}, data};
    repeat (ByteW) acc = (acc >> 1) ^ (acc[0] ? poly : '0);
    return acc;
  endfunction

  task automatic predict_crc(input logic [ByteW-1:0] data, input logic first,
                             input logic last);
    crc_result_t res;
    crc_state = crc_fold(first ? init_word : crc_state, data, poly_tab[poly_sel]);
    res.crc   = crc_state;
    res.done  = last;
    crc_expected_q.push_back(res);
  endtask

  task automatic note_error(input string what);
    error_count++;
    if (error_count <= MaxReports) $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  task automatic check_result(input logic [CrcW-1:0] crc, input logic done);
    crc_result_t exp_res;
    results_checked++;
    if (crc_expected_q.size() == 0) begin
      note_error($sformatf("unexpected beat crc=%h done=%b", crc, done));
    end else begin
      exp_res = crc_expected_q.pop_front();
      if (crc !== exp_res.crc)
        note_error($sformatf("crc expected %h actual %h", exp_res.crc, crc));
      if (done !== exp_res.done)
        note_error($sformatf("done expected %b actual %b", exp_res.done, done));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata, m_axis_tlast);
    m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle);
  end

  task automatic send_beat(input logic [ByteW-1:0] data, input logic first,
                           input logic last);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= first;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_crc(data, first, last);
    beats_sent++;
    if (last) messages_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (crc_expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_POLY_SELECT: poly_sel  = data[SelW-1:0];
      CFG_INIT_VALUE:  init_word = data;
      CFG_POLY_ZERO:   poly_tab[0] = data;
      CFG_POLY_ONE:    poly_tab[1] = data;
      CFG_POLY_TWO:    poly_tab[2] = data;
      CFG_POLY_THREE:  poly_tab[3] = data;
      default: ;
    endcase
    reg_writes++;
    @(posedge clk_i);
  endtask

  // kind 0: random, 1: all-zero extremes, 2: all-one extremes
  task automatic load_setup(input int kind);
    logic [CfgDataW-1:0] words [6];
    for (int k = 0; k < 6; k++) begin
      case (kind)
        1:       words[k] = '0;
        2:       words[k] = '1;
        default: words[k] = CfgDataW'($urandom);
      endcase
    end
    if (kind != 0) words[CFG_POLY_SELECT] = CfgDataW'($urandom);
    if (kind == 1) words[CFG_POLY_ZERO + $urandom_range(3)] = CfgDataW'($urandom) | 16'h8000;
    for (int k = 0; k < 6; k++) write_reg(CfgIdxW'(k), words[k]);
  endtask

  task automatic send_message(input int len, input bit well_formed);
    for (int k = 0; k < len; k++) begin
      if (well_formed) send_beat(ByteW'($urandom), k == 0, k == len - 1);
      else send_beat(ByteW'($urandom), 1'($urandom), 1'($urandom));
    end
  endtask

  task automatic test_reset_table();
    send_beat(8'h00, 1'b0, 1'b0);   // opening byte without first flag, from reset zero
    send_beat(8'hFF, 1'b0, 1'b1);
    send_beat(8'h01, 1'b0, 1'b0);   // continues after last without first
    send_beat(8'hFF, 1'b1, 1'b1);   // one-byte message
    send_beat(8'h5A, 1'b1, 1'b0);
    send_beat(8'hA5, 1'b0, 1'b0);
    send_beat(8'h80, 1'b0, 1'b1);
    wait_drained();
  endtask

  task automatic test_each_poly();
    write_reg(CFG_INIT_VALUE, 16'hFFFF);
    for (int s = 0; s < NumPoly; s++) begin
      // upper bits of the select write are dropped
      write_reg(CFG_POLY_SELECT, {14'h3FFF, 2'(s)} & (s[0] ? 16'hFFFF : 16'hFFFD) | 2'(s));
      write_reg(CfgIdxSpareLo, 16'hFFFF);
      write_reg(CfgIdxSpareHi, 16'h0000);
      send_beat(8'hFF, 1'b1, 1'b0);
      send_beat(8'h00, 1'b0, 1'b0);
      send_beat(8'h80, 1'b0, 1'b1);
      wait_drained();
    end
  endtask

  task automatic test_poly_extremes();
    write_reg(CFG_INIT_VALUE, 16'h0000);
    write_reg(CFG_POLY_ZERO, 16'h0000);
    write_reg(CFG_POLY_SELECT, 16'h0000);
    send_beat(8'hFF, 1'b1, 1'b0);
    send_beat(8'h01, 1'b0, 1'b1);
    wait_drained();
    write_reg(CFG_POLY_THREE, 16'hFFFF);
    write_reg(CFG_POLY_SELECT, 16'h0003);
    send_beat(8'hFF, 1'b1, 1'b0);
    send_beat(8'h7F, 1'b0, 1'b0);
    send_beat(8'h00, 1'b0, 1'b1);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int unsigned s_pct, input int unsigned r_pct,
                                     input int unsigned n_beats);
    int unsigned start;
    send_idle = s_pct;
    recv_idle = r_pct;
    for (int chunk = 0; chunk < 3; chunk++) begin
      wait_drained();
      load_setup((chunk + $urandom_range(2)) % 3);
      start = beats_sent;
      while (beats_sent - start < n_beats / 3) begin
        if ($urandom_range(99) < 85)
          send_message(($urandom_range(9) == 0) ? $urandom_range(20) + 1 : $urandom_range(8) + 1,
                       1'b1);
        else send_message($urandom_range(4) + 1, 1'b0);
      end
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    send_idle = 0;
    recv_idle = 0;
    load_setup(0);
    hold_asked++;
    for (int m = 0; m < 8; m++) send_message(5, 1'b1);
    wait_drained();
  endtask

  initial begin
    crc_state = '0;
    poly_sel  = '0;
    init_word = '0;
    poly_tab[0] = PolyResetZero;
    poly_tab[1] = PolyResetOne;
    poly_tab[2] = PolyResetTwo;
    poly_tab[3] = PolyResetThree;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_reset_table();
    test_each_poly();
    test_poly_extremes();
    test_random_traffic(30, 66, 270);
    test_random_traffic(66, 30, 270);
    test_random_traffic(0, 0, 270);
    test_backpressure();

    repeat (8) @(posedge clk_i);
    if (crc_expected_q.size() != 0) note_error("results still pending at end");
    $display("covered %0d beats in %0d messages, %0d results checked", beats_sent,
             messages_sent, results_checked);
    $display("%0d register writes across random, all-zero and all-one setups, %0d errors",
             reg_writes, error_count);
    if (error_count == 0) begin
      $display("[selectable_crc16_reflected_unit] OK");
    end else begin
      $display("[selectable_crc16_reflected_unit] ERROR");
    end
    $finish;
  end

endmodule
